>>> rtl/pf_pkg.sv
// Shared types and constants for the prime factorizer.
// Used by pf_controller, pf_datapath and prime_factorizer_core. No dependencies.
package pf_pkg;

  // width of the factor result port
  localparam int FACTOR_BITS = 31;
  // width of the number input port
  localparam int INPUT_BITS  = 31;

  // controller -> datapath
  typedef struct packed {
    logic load;       // take a new number, trial divisor = 3
    logic halve;      // report a 2, shift the value right
    logic div_start;  // launch rest / trial
    logic div_step;   // apply the quotient/remainder just produced
    logic emit_rest;  // report the leftover prime, if above 1
    logic flush;      // send the held factor marked last
    logic nofactor;   // send the single "no factor" word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rest_gt1;   // remaining value above 1
    logic rest_odd;   // remaining value odd
    logic div_done;   // divider result ready this cycle
    logic loop_end;   // trial > rest / trial on a fresh divisor
  } status_t;

endpackage

>>> rtl/prime_factorizer_core.sv
// Top level of the trial-division prime factorizer.
// Depends on pf_pkg, pf_controller, pf_datapath (which holds pf_divider).

// Usage: raise start with a number while busy is low; the word is taken at
// that edge. Results come out one word per strobe pulse, smallest prime first
// with repeats; the final word of a number carries last. busy drops in the
// cycle that carries the final word, so the next number can be taken at the
// edge that ends it. Zero and one produce a single word with has_factor low
// and factor zero. The receiver cannot stall: every strobe pulse must be
// captured. Work per number: load and classify, one halving step per factor
// of two, then one division per trial divisor (odd divisors from 3 upward to
// about sqrt of the remaining value, plus one extra division per odd factor
// found) on the restoring divider, one quotient bit per cycle, and a
// close-out. A prime near 2^31 takes about 23000 divisions; small or smooth
// numbers take far fewer.
module prime_factorizer_core #(
  parameter int NUMBER_BITS = 31   // internal value width, 8..63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [pf_pkg::INPUT_BITS-1:0]  number,
  output logic                           strobe,
  output logic [pf_pkg::FACTOR_BITS-1:0] factor,
  output logic                           has_factor,
  output logic                           last
);

  pf_pkg::cmd_t    cmd;
  pf_pkg::status_t status;

  // sequencing only; all arithmetic lives in the datapath
  pf_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pf_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .number     (number),
    .status     (status),
    .strobe     (strobe),
    .factor     (factor),
    .has_factor (has_factor),
    .last       (last)
  );

  // a no-factor word always closes its number
  a_nofac_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !has_factor |-> last)
    else $error("no-factor word without last");

  // a non-final word only appears mid-job
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final word while idle");

  // nothing follows the final word in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("word right after last");

  // an accepted word starts a job
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("start not taken");

endmodule

>>> rtl/pf_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Standalone; instantiated by pf_datapath.
module pf_divider #(
  parameter int NUMBER_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] dividend,
  input  logic [NUMBER_BITS-1:0] divisor,
  output logic                   done,
  output logic [NUMBER_BITS-1:0] quotient,
  output logic [NUMBER_BITS-1:0] remainder
);

  localparam int CNT_W = $clog2(NUMBER_BITS + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [NUMBER_BITS-1:0] dsor;
  logic [NUMBER_BITS:0]   shifted;
  logic [NUMBER_BITS:0]   diff;

  assign shifted = {remainder, quotient[NUMBER_BITS-1]};
  assign diff    = shifted - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUMBER_BITS);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsor      <= divisor;
    end else if (run) begin
      if (!diff[NUMBER_BITS]) begin
        remainder <= diff[NUMBER_BITS-1:0];
        quotient  <= {quotient[NUMBER_BITS-2:0], 1'b1};
      end else begin
        remainder <= shifted[NUMBER_BITS-1:0];
        quotient  <= {quotient[NUMBER_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/pf_datapath.sv
// Factorizer datapath: remaining value, trial divisor, held factor, result register.
// Depends on pf_pkg and pf_divider.
module pf_datapath #(
  parameter int NUMBER_BITS = 31
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pf_pkg::cmd_t                       cmd,
  input  logic [pf_pkg::INPUT_BITS-1:0]      number,
  output pf_pkg::status_t                    status,
  output logic                               strobe,
  output logic [pf_pkg::FACTOR_BITS-1:0]     factor,
  output logic                               has_factor,
  output logic                               last
);

  logic [NUMBER_BITS-1:0] rest, rest_next;
  logic [NUMBER_BITS-1:0] trial, trial_next;
  logic [NUMBER_BITS-1:0] pend, pend_next;
  logic                   pend_valid, pend_valid_next;
  logic                   in_while, in_while_next;
  logic                   strobe_next, has_factor_next, last_next;
  logic [pf_pkg::FACTOR_BITS-1:0] factor_next;

  logic                   emit_en;
  logic [NUMBER_BITS-1:0] emit_val;

  logic                   div_done;
  logic [NUMBER_BITS-1:0] quo, rem;

  pf_divider #(.NUMBER_BITS(NUMBER_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (rest),
    .divisor   (trial),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign status.rest_gt1 = |rest[NUMBER_BITS-1:1];
  assign status.rest_odd = rest[0];
  assign status.div_done = div_done;
  assign status.loop_end = !in_while && (quo < trial);

  always_comb begin
    rest_next       = rest;
    trial_next      = trial;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    in_while_next   = in_while;
    strobe_next     = 1'b0;
    factor_next     = factor;
    has_factor_next = has_factor;
    last_next       = last;
    emit_en         = 1'b0;
    emit_val        = '0;

    if (cmd.load) begin
      rest_next       = (NUMBER_BITS)'(number);
      trial_next      = (NUMBER_BITS)'(3);
      pend_valid_next = 1'b0;
      in_while_next   = 1'b0;
    end
    if (cmd.halve) begin
      emit_en   = 1'b1;
      emit_val  = (NUMBER_BITS)'(2);
      rest_next = rest >> 1;
    end
    if (cmd.div_step) begin
      if (rem == '0) begin
        emit_en       = 1'b1;
        emit_val      = trial;
        rest_next     = quo;
        in_while_next = 1'b1;
      end else begin
        trial_next    = trial + (NUMBER_BITS)'(2);
        in_while_next = 1'b0;
      end
    end
    if (cmd.emit_rest && status.rest_gt1) begin
      emit_en  = 1'b1;
      emit_val = rest;
    end

    // one factor is held back so the final one can be flagged last
    if (emit_en) begin
      if (pend_valid) begin
        strobe_next     = 1'b1;
        factor_next     = (pf_pkg::FACTOR_BITS)'(pend);
        has_factor_next = 1'b1;
        last_next       = 1'b0;
      end
      pend_next       = emit_val;
      pend_valid_next = 1'b1;
    end
    if (cmd.flush) begin
      strobe_next     = 1'b1;
      factor_next     = (pf_pkg::FACTOR_BITS)'(pend);
      has_factor_next = 1'b1;
      last_next       = 1'b1;
      pend_valid_next = 1'b0;
    end
    if (cmd.nofactor) begin
      strobe_next     = 1'b1;
      factor_next     = '0;
      has_factor_next = 1'b0;
      last_next       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      in_while   <= 1'b0;
    end else begin
      strobe     <= strobe_next;
      pend_valid <= pend_valid_next;
      in_while   <= in_while_next;
    end
  end

  always_ff @(posedge clk) begin
    rest       <= rest_next;
    trial      <= trial_next;
    pend       <= pend_next;
    factor     <= factor_next;
    has_factor <= has_factor_next;
    last       <= last_next;
  end

endmodule

>>> rtl/pf_controller.sv
// Factorizer sequencer: one-hot state machine issuing datapath commands.
// Depends on pf_pkg.
module pf_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pf_pkg::status_t status,
  output pf_pkg::cmd_t    cmd,
  output logic            busy
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_HALVE  = 7'b0000100,
    S_LAUNCH = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   nofac, nofac_next;  // zero or one: single word on the way out

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    nofac_next = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.rest_gt1) begin
          state_next = S_HALVE;
        end else begin
          nofac_next = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_HALVE: begin
        if (!status.rest_odd) begin
          cmd.halve = 1'b1;
        end else begin
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.loop_end) begin
            state_next = S_FINISH;
          end else begin
            cmd.div_step = 1'b1;
            state_next   = S_LAUNCH;
          end
        end
      end
      S_FINISH: begin
        cmd.emit_rest = 1'b1;
        state_next    = S_FLUSH;
      end
      S_FLUSH: begin
        if (nofac) begin
          cmd.nofactor = 1'b1;
        end else begin
          cmd.flush = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nofac <= 1'b0;
    end else begin
      state <= state_next;
      nofac <= nofac_next;
    end
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for prime_factorizer_core: drives numbers, predicts factor words.
// Depends on pf_pkg and the prime_factorizer_core RTL; needs nothing else to run.
`timescale 1ns / 100ps

module testbench;

  localparam int  WATCHDOG_LIMIT = 4_000_000;  // silent cycles
  localparam int  RANDOM_NUMBERS = 100;
  localparam int  SETTLE_CYCLES  = 20;
  localparam longint unsigned NUMBER_MAX = (64'd1 << pf_pkg::INPUT_BITS) - 1;

  // one result word as seen on the output ports
  typedef struct packed {
    logic [pf_pkg::FACTOR_BITS-1:0] factor;
    logic                           has_factor;
    logic                           last;
  } factor_word_t;

  // Scoreboard: expands each accepted number into its expected factor words,
  // then matches the DUT output against them in order.
  class factor_scoreboard;
    factor_word_t pending_words[$];
    int mismatches;
    int numbers_seen;
    int words_checked;
    int most_factors;

    function new();
      mismatches    = 0;
      numbers_seen  = 0;
      words_checked = 0;
      most_factors  = 0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // trial division: 2s first, then odd divisors while d*d <= rest
    function void note_number(logic [pf_pkg::INPUT_BITS-1:0] num);
      longint unsigned rest;
      longint unsigned d;
      longint unsigned found[$];
      factor_word_t    w;
      numbers_seen++;
      rest = num;
      if (rest <= 1) begin
        w.factor     = '0;
        w.has_factor = 1'b0;
        w.last       = 1'b1;
        pending_words = {pending_words, w};
        return;
      end
      while ((rest & 1) == 0) begin
        found = {found, 64'd2};
        rest = rest >> 1;
      end
      d = 3;
      while (d <= rest / d) begin
        while (rest % d == 0) begin
          found = {found, d};
          rest = rest / d;
        end
        d += 2;
      end
      if (rest > 2) found = {found, rest};
      if (found.size() > most_factors) most_factors = found.size();
      for (int k = 0; k < found.size(); k++) begin
        w.factor     = found[k][pf_pkg::FACTOR_BITS-1:0];
        w.has_factor = 1'b1;
        w.last       = (k == found.size() - 1);
        pending_words = {pending_words, w};
      end
    endfunction

    function void check_word(factor_word_t got);
      factor_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: factor %0d has_factor %0b last %0b",
                 $time, got.factor, got.has_factor, got.last);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (got.factor !== want.factor) begin
        $display("%0t: factor mismatch: expected %0d actual %0d",
                 $time, want.factor, got.factor);
        mismatches++;
      end
      if (got.has_factor !== want.has_factor) begin
        $display("%0t: has_factor mismatch: expected %0b actual %0b",
                 $time, want.has_factor, got.has_factor);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b actual %0b",
                 $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [pf_pkg::INPUT_BITS-1:0]  number;
  logic                           strobe;
  logic [pf_pkg::FACTOR_BITS-1:0] factor;
  logic                           has_factor;
  logic                           last;

  factor_scoreboard factors = new();
  int  idle_cycles;
  bit  gap_free;   // burst mode: sender never idles while set

  prime_factorizer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .number     (number),
    .strobe     (strobe),
    .factor     (factor),
    .has_factor (has_factor),
    .last       (last)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output monitor. Outputs are registered, so sampling right at the rising
  // edge sees the values of the cycle that edge closes. Every strobe is a word.
  always @(posedge clk) begin
    if (!rst && strobe) factors.check_word('{factor, has_factor, last});
  end

  // Watchdog: counts cycles with neither an accepted number nor a result word.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time, factors.pending());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one number. start is left high after acceptance so that a zero gap
  // keeps it high into the next word with a single assignment per edge.
  task automatic send_number(input logic [pf_pkg::INPUT_BITS-1:0] value);
    int gap;
    if (!gap_free && $urandom_range(0, 9) == 0) gap_free = 1'b1;
    else if (gap_free && $urandom_range(0, 5) == 0) gap_free = 1'b0;
    gap = gap_free ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    number <= value;
    do @(posedge clk); while (busy);
    factors.note_number(value);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected word has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (factors.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random numbers are built so trial division stays short: the largest share
  // are products of small factors, some carry one cofactor below 2^16, some
  // are shifted odd bytes that reach the top bits. Arbitrary 31-bit primes
  // would run the full trial-division loop.
  function automatic logic [pf_pkg::INPUT_BITS-1:0] pick_number();
    longint unsigned v;
    longint unsigned f;
    int kind;
    kind = $urandom_range(0, 99);
    v = 1;
    if (kind < 45) begin
      repeat ($urandom_range(1, 12)) begin
        f = $urandom_range(2, 255);
        if (v * f <= NUMBER_MAX) v = v * f;
      end
    end else if (kind < 70) begin
      repeat ($urandom_range(0, 4)) begin
        f = $urandom_range(2, 255);
        if (v * f <= NUMBER_MAX) v = v * f;
      end
      f = $urandom_range(2, 65535);
      if (v * f <= NUMBER_MAX) v = v * f;
    end else if (kind < 85) begin
      v = $urandom_range(0, 65535);
    end else if (kind < 95) begin
      v = longint'($urandom_range(0, 127) * 2 + 1) << $urandom_range(0, 23);
    end else begin
      v = $urandom_range(0, 3);
    end
    return v[pf_pkg::INPUT_BITS-1:0];
  endfunction

  // Directed numbers: zero and one (no factor), tiny primes, exact squares on
  // the d*d == rest boundary, 30 twos (most words), many repeated 3s, the
  // all-ones value (a prime, so the longest loop and the wide square test),
  // and values with a large prime left over at the end.
  localparam longint unsigned DIRECTED [0:17] = '{
    0, 1, 2, 3, 4, 9, 15, 25, 49, 5982, 65521, 131042, 1042441,
    1073741824, 1162261467, 1073741823, 2147483646, 2147483647
  };

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    number      = '0;
    idle_cycles = 0;
    gap_free    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) send_number(DIRECTED[i][pf_pkg::INPUT_BITS-1:0]);
    // let the pipeline empty completely once before random traffic
    drain_results();

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      if ($urandom_range(0, 11) == 0) drain_results();
      send_number(pick_number());
    end

    drain_results();
    $display("Sent %0d numbers, checked %0d factor words, up to %0d factors per number.",
             factors.numbers_seen, factors.words_checked, factors.most_factors);
    $display("Covered zero/one, powers of two, squares, smooth values and 31-bit primes.");
    if (factors.mismatches == 0 && factors.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
